// ===== hdl/sldf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sldf_pkg
// Shared types, codes and helpers for the sync/length/checksum deframer.
// ----------------------------------------------------------------------------
package sldf_pkg;

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_VALUE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LENGTH = 1'b1;
    localparam int CFG_DATA_W = 16;

    // Reset values of the configuration registers
    localparam logic [7:0]  SYNC_RESET    = 8'hA5;
    localparam logic [15:0] MAXLEN_RESET  = 16'hFFFF;

    // Smallest legal length: code byte plus checksum byte
    localparam logic [15:0] MIN_LENGTH    = 16'd2;

    // Known transaction codes
    localparam logic [7:0] CODE_STATUS    = 8'h50;
    localparam logic [7:0] CODE_VITALS    = 8'h75;
    localparam logic [7:0] CODE_PARAM_A   = 8'h57;
    localparam logic [7:0] CODE_PARAM_B   = 8'h77;

    typedef enum logic [2:0] {
        PH_HUNT    = 3'd0,
        PH_LEN_LO  = 3'd1,
        PH_LEN_HI  = 3'd2,
        PH_CODE    = 3'd3,
        PH_PAYLOAD = 3'd4,
        PH_CHECK   = 3'd5
    } phase_t;

    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_END     = 2'd1,
        KIND_DISCARD = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_BADSUM = 2'd1,
        ST_BADLEN = 2'd2,
        ST_NOSYNC = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CLS_STATUS  = 2'd0,
        CLS_VITALS  = 2'd1,
        CLS_PARAM   = 2'd2,
        CLS_UNKNOWN = 2'd3
    } class_t;

    // Live configuration seen by the parser
    typedef struct packed {
        logic [7:0]  sync_value;
        logic [15:0] max_length;
    } cfg_t;

    // One result item
    typedef struct packed {
        kind_t       result_kind;
        logic [7:0]  frame_code;
        class_t      code_class;
        logic [7:0]  data_byte;
        logic [15:0] byte_index;
        logic        last;
        status_t     status;
    } result_t;

    // Map a transaction code to its class
    function automatic class_t class_of(input logic [7:0] code);
        class_t cls;
        case (code)
            CODE_STATUS:                cls = CLS_STATUS;
            CODE_VITALS:                cls = CLS_VITALS;
            CODE_PARAM_A, CODE_PARAM_B: cls = CLS_PARAM;
            default:                    cls = CLS_UNKNOWN;
        endcase
        return cls;
    endfunction

endpackage

// ===== hdl/sldf_cfg_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sldf_cfg_regs
// Configuration register file: sync byte value and length limit.
// ----------------------------------------------------------------------------
module sldf_cfg_regs
    import sldf_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                 cfg
);

    logic [7:0]  sync_value_reg;
    logic [15:0] max_length_reg;

    // Writes are always taken
    assign cfg_ready = 1'b1;

    // Register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sync_value_reg <= SYNC_RESET;
            max_length_reg <= MAXLEN_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_SYNC_VALUE: sync_value_reg <= cfg_data[7:0];
                CFG_MAX_LENGTH: max_length_reg <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    assign cfg.sync_value = sync_value_reg;
    assign cfg.max_length = max_length_reg;

endmodule

// ===== hdl/sldf_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sldf_parser
// Frame state machine: sync hunt, length, code, payload and checksum check.
// Produces at most one result per accepted byte.
// ----------------------------------------------------------------------------
module sldf_parser
    import sldf_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_fire,
    input  logic [7:0] rx_byte,
    input  cfg_t       cfg,
    output logic       res_valid,
    output result_t    res
);

    phase_t      phase_reg, phase_next;
    logic [15:0] frame_length_reg, frame_length_next;
    logic [15:0] bytes_left_reg, bytes_left_next;
    logic [15:0] payload_index_reg, payload_index_next;
    logic [7:0]  running_sum_reg, running_sum_next;
    logic [7:0]  current_code_reg, current_code_next;

    logic [15:0] len_full;
    logic [7:0]  sum_plus;
    logic [7:0]  res_code;

    // State registers, advance only on an accepted byte
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg         <= PH_HUNT;
            frame_length_reg  <= '0;
            bytes_left_reg    <= '0;
            payload_index_reg <= '0;
            running_sum_reg   <= '0;
            current_code_reg  <= '0;
        end else if (in_fire) begin
            phase_reg         <= phase_next;
            frame_length_reg  <= frame_length_next;
            bytes_left_reg    <= bytes_left_next;
            payload_index_reg <= payload_index_next;
            running_sum_reg   <= running_sum_next;
            current_code_reg  <= current_code_next;
        end
    end

    assign len_full = {rx_byte, frame_length_reg[7:0]};
    assign sum_plus = running_sum_reg + rx_byte;

    // Next state and result
    always_comb begin
        phase_next         = phase_reg;
        frame_length_next  = frame_length_reg;
        bytes_left_next    = bytes_left_reg;
        payload_index_next = payload_index_reg;
        running_sum_next   = running_sum_reg;
        current_code_next  = current_code_reg;

        res_valid       = 1'b0;
        res_code        = 8'h00;
        res.result_kind = KIND_PAYLOAD;
        res.data_byte   = 8'h00;
        res.byte_index  = 16'h0000;
        res.last        = 1'b0;
        res.status      = ST_OK;

        case (phase_reg)
            PH_LEN_LO: begin
                frame_length_next = {8'h00, rx_byte};
                running_sum_next  = sum_plus;
                phase_next        = PH_LEN_HI;
            end
            PH_LEN_HI: begin
                frame_length_next = len_full;
                running_sum_next  = sum_plus;
                if (len_full < MIN_LENGTH || len_full > cfg.max_length) begin
                    // Length out of range: end frame now
                    phase_next      = PH_HUNT;
                    res_valid       = 1'b1;
                    res.result_kind = KIND_END;
                    res.last        = 1'b1;
                    res.status      = ST_BADLEN;
                end else begin
                    phase_next = PH_CODE;
                end
            end
            PH_CODE: begin
                current_code_next  = rx_byte;
                running_sum_next   = sum_plus;
                payload_index_next = '0;
                bytes_left_next    = frame_length_reg - MIN_LENGTH;
                phase_next = (frame_length_reg != MIN_LENGTH) ? PH_PAYLOAD : PH_CHECK;
            end
            PH_PAYLOAD: begin
                res_valid          = 1'b1;
                res_code           = current_code_reg;
                res.result_kind    = KIND_PAYLOAD;
                res.data_byte      = rx_byte;
                res.byte_index     = payload_index_reg;
                running_sum_next   = sum_plus;
                payload_index_next = payload_index_reg + 16'd1;
                bytes_left_next    = bytes_left_reg - 16'd1;
                if (bytes_left_reg == 16'd1) begin
                    phase_next = PH_CHECK;
                end
            end
            PH_CHECK: begin
                phase_next      = PH_HUNT;
                res_valid       = 1'b1;
                res_code        = current_code_reg;
                res.result_kind = KIND_END;
                res.last        = 1'b1;
                res.status      = (rx_byte == running_sum_reg) ? ST_OK : ST_BADSUM;
            end
            default: begin
                // Hunting for the sync byte
                phase_next = PH_HUNT;
                if (rx_byte == cfg.sync_value) begin
                    running_sum_next   = rx_byte;
                    current_code_next  = '0;
                    frame_length_next  = '0;
                    bytes_left_next    = '0;
                    payload_index_next = '0;
                    phase_next         = PH_LEN_LO;
                end else begin
                    res_valid       = 1'b1;
                    res.result_kind = KIND_DISCARD;
                    res.data_byte   = rx_byte;
                    res.status      = ST_NOSYNC;
                end
            end
        endcase

        res.frame_code = res_code;
        res.code_class = class_of(res_code);
    end

endmodule

// ===== hdl/sldf_out_reg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sldf_out_reg
// Result register: holds one result until the sink takes it, and lets a
// new byte in whenever it is empty or being drained in the same cycle.
// ----------------------------------------------------------------------------
module sldf_out_reg
    import sldf_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    in_fire,
    input  logic    res_valid,
    input  result_t res,
    output logic    can_accept,
    output logic    m_valid,
    input  logic    m_ready,
    output result_t m_res
);

    logic    valid_reg, valid_next;
    result_t data_reg;

    // Room for a new result if empty or the held one leaves this cycle
    assign can_accept = !valid_reg || m_ready;

    always_comb begin
        valid_next = valid_reg;
        if (m_ready) begin
            valid_next = 1'b0;
        end
        if (in_fire && res_valid) begin
            valid_next = 1'b1;
        end
    end

    // Valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Payload, no reset needed
    always_ff @(posedge aclk) begin
        if (in_fire && res_valid) begin
            data_reg <= res;
        end
    end

    assign m_valid = valid_reg;
    assign m_res   = data_reg;

endmodule

// ===== hdl/sync_length_checksum_deframer_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sync_length_checksum_deframer_top
// Serial frame deframer: sync byte, 16-bit little-endian length, code,
// payload and 8-bit additive checksum. Payload bytes are forwarded as they
// arrive; a frame-end result reports checksum or length status.
//
//   Channel  Direction  Handshake             Payload
//   s_       in         s_valid / s_ready     s_rx_byte
//   m_       out        m_valid / m_ready     kind, code, class, data, index,
//                                             last, status
//   cfg_     in         cfg_valid / cfg_ready cfg_index, cfg_data
//
// One received byte per cycle; a byte's result sits in the output register
// in the cycle after its transfer. Throughput is set by the single result
// register: s_ready is high when it is empty or drained in the same cycle.
// Reset (aresetn low, synchronous) returns to sync hunting with default
// configuration. A stall on m_ stalls s_ only while a result is held.
// ----------------------------------------------------------------------------
module sync_length_checksum_deframer_top
    import sldf_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [7:0]            s_rx_byte,

    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [1:0]            m_result_kind,
    output logic [7:0]            m_frame_code,
    output logic [1:0]            m_code_class,
    output logic [7:0]            m_data_byte,
    output logic [15:0]           m_byte_index,
    output logic                  m_last,
    output logic [1:0]            m_status,

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t    cfg;
    logic    in_fire;
    logic    res_valid;
    result_t res;
    result_t m_res;

    assign in_fire = s_valid && s_ready;

    sldf_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    sldf_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_fire   (in_fire),
        .rx_byte   (s_rx_byte),
        .cfg       (cfg),
        .res_valid (res_valid),
        .res       (res)
    );

    sldf_out_reg u_out (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_fire    (in_fire),
        .res_valid  (res_valid),
        .res        (res),
        .can_accept (s_ready),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_res      (m_res)
    );

    assign m_result_kind = m_res.result_kind;
    assign m_frame_code  = m_res.frame_code;
    assign m_code_class  = m_res.code_class;
    assign m_data_byte   = m_res.data_byte;
    assign m_byte_index  = m_res.byte_index;
    assign m_last        = m_res.last;
    assign m_status      = m_res.status;

    // Frame-end marker only on frame-end results
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_last == (m_result_kind == KIND_END)))
        else $error("last flag does not match result kind");

    // Payload results are clean and carry the class of their code
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_result_kind == KIND_PAYLOAD) |->
            (m_status == ST_OK && m_code_class == class_of(m_frame_code)))
        else $error("payload result with bad status or class");

    // Discarded bytes carry no frame code
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_result_kind == KIND_DISCARD) |->
            (m_status == ST_NOSYNC && m_frame_code == 8'h00 && m_byte_index == 16'h0000))
        else $error("discard result malformed");

    // A byte that yields a result with an empty register shows up next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && res_valid) |=> m_valid)
        else $error("result lost in output register");

endmodule

// ===== tb/sync_length_checksum_deframer_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sync_length_checksum_deframer_top_tb
// Self-checking bench for the serial frame deframer. Byte streams of good
// frames, checksum errors, length errors, cut-off frames and line noise are
// pushed through the s_ channel. An in-bench parser predicts every result,
// and each m_ transfer is checked field by field against the oldest entry.
// Both sides idle at random. One phase runs with no idling, and the output
// is held off for a long stretch so that the input stalls. The registers are
// rewritten between phases, the extremes among them.
// ----------------------------------------------------------------------------
module sync_length_checksum_deframer_top_tb;

    import sldf_pkg::*;

    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 4;
    localparam int DRAIN_LIMIT   = 10000;
    localparam longint TIMEOUT_NS = 64'd8_000_000;

    // ------------------------------------------------------------------
    // Frame parser mirror and store of results still to arrive
    // ------------------------------------------------------------------
    class deframe_scoreboard;
        logic [7:0]  frame_sync;
        logic [15:0] length_limit;
        phase_t      parse_phase;
        logic [15:0] frame_len;
        logic [15:0] remaining;
        logic [15:0] payload_pos;
        logic [7:0]  sum;
        logic [7:0]  code;
        result_t     pending_results[$];
        int          errors;

        function new();
            frame_sync   = SYNC_RESET;
            length_limit = MAXLEN_RESET;
            parse_phase  = PH_HUNT;
            frame_len    = '0;
            remaining    = '0;
            payload_pos  = '0;
            sum          = '0;
            code         = '0;
            errors       = 0;
        endfunction

        function void set_reg(input logic [CFG_IDX_W-1:0] idx,
                              input logic [CFG_DATA_W-1:0] data);
            if (idx == CFG_SYNC_VALUE)
                frame_sync = data[7:0];
            else
                length_limit = data;
        endfunction

        function class_t classify(input logic [7:0] c);
            if (c == CODE_STATUS)
                return CLS_STATUS;
            if (c == CODE_VITALS)
                return CLS_VITALS;
            if (c == CODE_PARAM_A || c == CODE_PARAM_B)
                return CLS_PARAM;
            return CLS_UNKNOWN;
        endfunction

        function void push_result(input kind_t kind, input logic [7:0] c,
                                  input logic [7:0] data, input logic [15:0] pos,
                                  input logic last_flag, input status_t st);
            result_t r;
            r.result_kind = kind;
            r.frame_code  = c;
            r.code_class  = classify(c);
            r.data_byte   = data;
            r.byte_index  = pos;
            r.last        = last_flag;
            r.status      = st;
            pending_results.push_back(r);
        endfunction

        // Advance the parser by one accepted byte
        function void predict_byte(input logic [7:0] b);
            case (parse_phase)
                PH_LEN_LO: begin
                    frame_len   = {8'h00, b};
                    sum         = sum + b;
                    parse_phase = PH_LEN_HI;
                end
                PH_LEN_HI: begin
                    frame_len[15:8] = b;
                    sum             = sum + b;
                    if (frame_len < MIN_LENGTH || frame_len > length_limit) begin
                        parse_phase = PH_HUNT;
                        push_result(KIND_END, 8'h00, 8'h00, 16'h0000, 1'b1, ST_BADLEN);
                    end else begin
                        parse_phase = PH_CODE;
                    end
                end
                PH_CODE: begin
                    code        = b;
                    sum         = sum + b;
                    payload_pos = '0;
                    remaining   = frame_len - MIN_LENGTH;
                    parse_phase = (remaining != 0) ? PH_PAYLOAD : PH_CHECK;
                end
                PH_PAYLOAD: begin
                    push_result(KIND_PAYLOAD, code, b, payload_pos, 1'b0, ST_OK);
                    sum         = sum + b;
                    payload_pos = payload_pos + 16'd1;
                    remaining   = remaining - 16'd1;
                    if (remaining == 0)
                        parse_phase = PH_CHECK;
                end
                PH_CHECK: begin
                    parse_phase = PH_HUNT;
                    push_result(KIND_END, code, 8'h00, 16'h0000, 1'b1,
                                (b == sum) ? ST_OK : ST_BADSUM);
                end
                default: begin
                    parse_phase = PH_HUNT;
                    if (b == frame_sync) begin
                        sum         = b;
                        code        = '0;
                        frame_len   = '0;
                        remaining   = '0;
                        payload_pos = '0;
                        parse_phase = PH_LEN_LO;
                    end else begin
                        push_result(KIND_DISCARD, 8'h00, b, 16'h0000, 1'b0, ST_NOSYNC);
                    end
                end
            endcase
        endfunction

        task report_mismatch(input string msg);
            errors++;
            if (errors <= 100)
                $display("[%0t] mismatch: %s", $time, msg);
        endtask

        task compare_field(input string name, input logic [15:0] got_val,
                           input logic [15:0] want_val);
            if (got_val !== want_val)
                report_mismatch($sformatf("%s got %0h want %0h", name, got_val, want_val));
        endtask

        task check_result(input result_t got);
            result_t want;
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result kind %0d data %02h",
                                          got.result_kind, got.data_byte));
                return;
            end
            want = pending_results.pop_front();
            compare_field("result_kind", got.result_kind, want.result_kind);
            compare_field("frame_code", got.frame_code, want.frame_code);
            compare_field("code_class", got.code_class, want.code_class);
            compare_field("data_byte", got.data_byte, want.data_byte);
            compare_field("byte_index", got.byte_index, want.byte_index);
            compare_field("last", got.last, want.last);
            compare_field("status", got.status, want.status);
        endtask
    endclass

    // ------------------------------------------------------------------
    // Signals and DUT
    // ------------------------------------------------------------------
    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    logic [7:0]            s_rx_byte = 8'h00;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    logic [1:0]            m_result_kind;
    logic [7:0]            m_frame_code;
    logic [1:0]            m_code_class;
    logic [7:0]            m_data_byte;
    logic [15:0]           m_byte_index;
    logic                  m_last;
    logic [1:0]            m_status;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_SYNC_VALUE;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    deframe_scoreboard sb = new();
    bit          quiet    = 1'b0;   // no idling on either side
    bit          hold_req = 1'b0;   // asks the receiver for a long hold-off
    int unsigned bytes_sent = 0;

    sync_length_checksum_deframer_top i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_rx_byte     (s_rx_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_result_kind (m_result_kind),
        .m_frame_code  (m_frame_code),
        .m_code_class  (m_code_class),
        .m_data_byte   (m_data_byte),
        .m_byte_index  (m_byte_index),
        .m_last        (m_last),
        .m_status      (m_status),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // Clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Run limit
    initial begin
        #(TIMEOUT_NS);
        $display("sync_length_checksum_deframer_top test failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Result side: random backpressure, one long hold-off on request
    // ------------------------------------------------------------------
    initial begin
        result_t got;
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready) begin
                got.result_kind = kind_t'(m_result_kind);
                got.frame_code  = m_frame_code;
                got.code_class  = class_t'(m_code_class);
                got.data_byte   = m_data_byte;
                got.byte_index  = m_byte_index;
                got.last        = m_last;
                got.status      = status_t'(m_status);
                sb.check_result(got);
            end
            if (hold_req && aresetn) begin
                hold_req = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            m_ready <= quiet || ($urandom_range(99) >= 20);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus tasks
    // ------------------------------------------------------------------

    // One byte transfer; valid stays high on return until the next call
    task automatic send_byte(input logic [7:0] b);
        if (!quiet && $urandom_range(99) < 20) begin
            s_valid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < 20)
                @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_rx_byte <= b;
        do
            @(posedge aclk);
        while (!s_ready);
        sb.predict_byte(b);
        bytes_sent++;
    endtask

    // Whole frame, optionally with a bad checksum or cut off early
    task automatic send_frame(input logic [7:0] code, input int unsigned plen,
                              input bit bad_sum, input bit cut);
        logic [7:0]  frame_bytes[$];
        logic [15:0] flen;
        logic [7:0]  csum;
        int unsigned keep;
        flen        = 16'(plen) + MIN_LENGTH;
        frame_bytes = {sb.frame_sync, flen[7:0], flen[15:8], code};
        repeat (plen)
            frame_bytes.push_back(8'($urandom_range(255)));
        csum = '0;
        foreach (frame_bytes[i])
            csum = csum + frame_bytes[i];
        frame_bytes.push_back(bad_sum ? csum + 8'($urandom_range(1, 255)) : csum);
        keep = cut ? $urandom_range(1, frame_bytes.size() - 1) : frame_bytes.size();
        for (int i = 0; i < keep; i++)
            send_byte(frame_bytes[i]);
    endtask

    // Header with an out-of-range length; the frame ends there
    task automatic send_bad_length(input logic [15:0] flen);
        send_byte(sb.frame_sync);
        send_byte(flen[7:0]);
        send_byte(flen[15:8]);
    endtask

    function automatic logic [7:0] pick_code();
        case ($urandom_range(5))
            0:       return CODE_STATUS;
            1:       return CODE_VITALS;
            2:       return CODE_PARAM_A;
            3:       return CODE_PARAM_B;
            4:       return 8'h00;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic logic [15:0] bad_length();
        logic [15:0] v;
        v = 16'($urandom_range(65535));
        if (v >= MIN_LENGTH && v <= sb.length_limit)
            v = 16'($urandom_range(1));
        return v;
    endfunction

    // Drain, let the block settle, then write both registers
    task automatic configure(input logic [7:0] sync_val, input logic [15:0] len_max);
        s_valid <= 1'b0;
        while (sb.pending_results.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_SYNC_VALUE;
        cfg_data  <= {8'($urandom_range(255)), sync_val};
        do
            @(posedge aclk);
        while (!cfg_ready);
        sb.set_reg(CFG_SYNC_VALUE, cfg_data);
        cfg_index <= CFG_MAX_LENGTH;
        cfg_data  <= len_max;
        do
            @(posedge aclk);
        while (!cfg_ready);
        sb.set_reg(CFG_MAX_LENGTH, cfg_data);
        cfg_valid <= 1'b0;
    endtask

    // Mostly well-formed frames with random content, plus errors and noise
    task automatic run_traffic(input int unsigned count);
        int unsigned start_count;
        int unsigned pick;
        int unsigned cap;
        int unsigned room;
        start_count = bytes_sent;
        while (bytes_sent - start_count < count) begin
            pick = $urandom_range(99);
            room = (sb.length_limit >= MIN_LENGTH) ? sb.length_limit - MIN_LENGTH : 0;
            cap  = ($urandom_range(9) == 0) ? 40 : 12;
            if (cap > room)
                cap = room;
            if (pick < 65)
                send_frame(pick_code(), $urandom_range(cap), $urandom_range(3) == 0, 1'b0);
            else if (pick < 75)
                send_bad_length(bad_length());
            else if (pick < 87)
                repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(255)));
            else
                send_frame(pick_code(), $urandom_range(cap), 1'b0, 1'b1);
        end
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: noise extremes, empty payload, bad checksum, short lengths
        send_byte(8'h00);
        send_byte(8'hFF);
        send_frame(CODE_STATUS, 0, 1'b0, 1'b0);
        send_frame(CODE_VITALS, 2, 1'b1, 1'b0);
        send_bad_length(16'h0000);
        send_bad_length(16'h0001);
        send_frame(CODE_PARAM_A, 1, 1'b0, 1'b0);

        // Only empty payloads fit
        configure(8'h00, MIN_LENGTH);
        run_traffic(300);

        // Long frame, with a long output hold-off first
        configure(8'hFF, 16'hFFFF);
        hold_req = 1'b1;
        send_frame(CODE_PARAM_B, 120, 1'b0, 1'b0);
        run_traffic(300);

        // Short limit, no idling on either side
        configure(8'($urandom_range(255)), 16'($urandom_range(3, 40)));
        quiet = 1'b1;
        run_traffic(350);
        quiet = 1'b0;

        // Limit below the minimum length: every frame is a length error
        configure(8'($urandom_range(255)), 16'd0);
        run_traffic(150);
        configure(8'($urandom_range(255)), 16'd1);
        run_traffic(100);

        // Back to the default sync byte, random limit, second hold-off
        configure(SYNC_RESET, 16'($urandom_range(2, 65535)));
        hold_req = 1'b1;
        run_traffic(350);

        // Wait for the last results, then a few idle cycles
        s_valid <= 1'b0;
        for (int i = 0; i < DRAIN_LIMIT && sb.pending_results.size() != 0; i++)
            @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (sb.pending_results.size() != 0)
            sb.report_mismatch($sformatf("%0d results never arrived",
                                         sb.pending_results.size()));

        if (sb.errors == 0)
            $display("sync_length_checksum_deframer_top test passed");
        else
            $display("sync_length_checksum_deframer_top test failed");
        $finish;
    end

endmodule
